[design/hdm_pkg.sv]
// hdm_pkg: shared types, constants and popcount helpers for the Hamming
// descriptor matcher. No dependencies.
package hdm_pkg;

  localparam int WORD_W    = 64;   // one descriptor word
  localparam int IN_WORDS  = 4;    // descriptor words carried by an input transfer
  localparam int PART_W    = 7;    // popcount of one 64-bit word
  localparam int DIST_W    = 9;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 16;
  localparam int THR_W     = 9;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [DIST_W-1:0] NO_DIST      = 9'd511;
  localparam logic [THR_W-1:0]  THRESH_RESET = 9'd50;

  // input action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_CAND  = 2'd2;

  // register word index
  localparam logic [0:0] REG_MATCH_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_CAND  = 2'd2
  } kind_t;

  typedef logic [PART_W-1:0] part_t;

  typedef struct packed {
    kind_t                   kind;
    part_t [IN_WORDS-1:0]    part;
    logic [IDX_W-1:0]        tidx;
    logic                    last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = v - ((v >> 1) & 32'h55555555);
    b = (a & 32'h33333333) + ((a >> 2) & 32'h33333333);
    c = (b + (b >> 4)) & 32'h0F0F0F0F;
    return 6'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
  endfunction

  function automatic part_t pop64(input logic [WORD_W-1:0] v);
    return part_t'(pop32(v[31:0])) + part_t'(pop32(v[63:32]));
  endfunction

endpackage

[design/hdm_front.sv]
// hdm_front: takes input transfers, holds the query descriptor and turns
// each candidate into per-word popcounts. Depends on hdm_pkg.
module hdm_front #(
  parameter int DESC_WORDS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_0,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_1,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_2,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_3,
  input  logic [hdm_pkg::IDX_W-1:0]     target_index,
  input  logic                          last_candidate,
  input  hdm_pkg::q_status_t            q_status,
  input  logic                          sweeping,
  output logic                          push,
  output hdm_pkg::q_entry_t             push_data
);

  localparam int USED_WORDS = (DESC_WORDS < hdm_pkg::IN_WORDS) ? DESC_WORDS
                                                                : hdm_pkg::IN_WORDS;

  logic [hdm_pkg::WORD_W-1:0] desc_w [hdm_pkg::IN_WORDS];
  logic [hdm_pkg::WORD_W-1:0] query  [USED_WORDS];
  logic                       accepted;
  logic                       is_load;
  hdm_pkg::part_t [hdm_pkg::IN_WORDS-1:0] part;

  assign desc_w[0] = desc_0;
  assign desc_w[1] = desc_1;
  assign desc_w[2] = desc_2;
  assign desc_w[3] = desc_3;

  assign in_stall = q_status.full | sweeping;
  assign accepted = in_valid & ~in_stall;
  assign is_load  = (action == hdm_pkg::ACT_LOAD);

  for (genvar w = 0; w < hdm_pkg::IN_WORDS; w++) begin : g_word
    if (w < USED_WORDS) begin : g_used
      assign part[w] = hdm_pkg::pop64(query[w] ^ desc_w[w]);

      always_ff @(posedge clk) begin
        if (rst) begin
          query[w] <= '0;
        end else if (accepted && is_load) begin
          query[w] <= desc_w[w];
        end
      end
    end else begin : g_unused
      assign part[w] = '0;
    end
  end

  always_comb begin
    push           = 1'b0;
    push_data.kind = hdm_pkg::KIND_CAND;
    push_data.part = part;
    push_data.tidx = target_index;
    push_data.last = last_candidate;
    unique case (action)
      hdm_pkg::ACT_CLEAR: begin
        push           = accepted;
        push_data.kind = hdm_pkg::KIND_CLEAR;
      end
      hdm_pkg::ACT_LOAD: begin
        push           = accepted;
        push_data.kind = hdm_pkg::KIND_LOAD;
      end
      hdm_pkg::ACT_CAND: begin
        push           = accepted;
        push_data.kind = hdm_pkg::KIND_CAND;
      end
      default: begin
        // unused code: dropped
        push = 1'b0;
      end
    endcase
  end

endmodule

[design/hdm_fifo.sv]
// hdm_fifo: short queue of classified items between front and back.
// Depends on hdm_pkg.
module hdm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hdm_pkg::q_entry_t  push_data,
  input  logic               pop,
  output hdm_pkg::q_entry_t  head,
  output hdm_pkg::q_status_t status
);

  hdm_pkg::q_entry_t               slots [hdm_pkg::Q_DEPTH];
  logic [hdm_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [hdm_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [hdm_pkg::Q_CNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign status.full  = (count == hdm_pkg::Q_CNT_W'(hdm_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/hdm_back.sv]
// hdm_back: executes queued items: distance table lookup, best/second
// tracking, result register and the table clearing pass. Depends on hdm_pkg.
module hdm_back #(
  parameter int MAX_TARGETS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hdm_pkg::q_entry_t             head,
  input  hdm_pkg::q_status_t            q_status,
  output logic                          pop,
  output logic                          sweeping,
  input  logic [hdm_pkg::THR_W-1:0]     threshold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          query_matched,
  output logic [hdm_pkg::IDX_W-1:0]     best_index,
  output logic [hdm_pkg::DIST_W-1:0]    best_distance,
  output logic [hdm_pkg::DIST_W-1:0]    second_distance,
  output logic [hdm_pkg::CNT_W-1:0]     match_count
);

  localparam int AW = $clog2(MAX_TARGETS);

  logic [hdm_pkg::DIST_W-1:0] dist_mem [MAX_TARGETS];
  logic [hdm_pkg::DIST_W-1:0] mem_rdata;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [hdm_pkg::DIST_W-1:0] mem_wdata;
  logic [AW-1:0]              sweep_cnt;

  // execute stage
  logic                       ex_valid;
  hdm_pkg::kind_t             ex_kind;
  logic [hdm_pkg::DIST_W-1:0] ex_dist;
  logic [hdm_pkg::IDX_W-1:0]  ex_tidx;
  logic                       ex_last;
  logic                       ex_fwd_hit;
  logic [hdm_pkg::DIST_W-1:0] ex_fwd_dist;

  // running trackers
  logic [hdm_pkg::DIST_W-1:0] run_best;
  logic [hdm_pkg::DIST_W-1:0] run_second;
  logic [hdm_pkg::IDX_W-1:0]  run_index;
  logic [hdm_pkg::CNT_W-1:0]  count;

  logic [hdm_pkg::DIST_W-1:0] stored;
  logic                       in_range;
  logic                       qualify;
  logic [hdm_pkg::DIST_W-1:0] cand_best;
  logic [hdm_pkg::DIST_W-1:0] cand_second;
  logic [hdm_pkg::IDX_W-1:0]  cand_index;
  logic                       emit;
  logic                       out_free;
  logic                       ex_done;
  logic                       accept;
  logic                       acc_write;
  logic [hdm_pkg::CNT_W-1:0]  count_next;
  logic [hdm_pkg::DIST_W-1:0] head_dist;

  assign rd_addr   = AW'(head.tidx);
  assign head_dist = hdm_pkg::DIST_W'(head.part[0]) + hdm_pkg::DIST_W'(head.part[1])
                   + hdm_pkg::DIST_W'(head.part[2]) + hdm_pkg::DIST_W'(head.part[3]);

  // candidate evaluation
  always_comb begin
    stored   = ex_fwd_hit ? ex_fwd_dist : mem_rdata;
    in_range = (32'(ex_tidx) < 32'(MAX_TARGETS));
    qualify  = (ex_kind == hdm_pkg::KIND_CAND) && in_range && (stored > ex_dist);
    cand_best   = run_best;
    cand_second = run_second;
    cand_index  = run_index;
    priority if (qualify && ex_dist < run_best) begin
      cand_second = run_best;
      cand_best   = ex_dist;
      cand_index  = ex_tidx;
    end else if (qualify && ex_dist < run_second) begin
      cand_second = ex_dist;
    end
  end

  assign emit      = ex_valid && (ex_kind == hdm_pkg::KIND_CAND) && ex_last;
  assign out_free  = ~out_valid | ~out_stall;
  assign ex_done   = ex_valid && (~emit || out_free);
  assign accept    = (cand_best != hdm_pkg::NO_DIST) && (cand_best <= threshold);
  assign acc_write = ex_done && emit && accept;
  assign count_next = (accept && count != {hdm_pkg::CNT_W{1'b1}}) ? count + 1'b1 : count;

  assign pop = ~q_status.empty && ~sweeping &&
               (~ex_valid || (ex_done && ex_kind != hdm_pkg::KIND_CLEAR));

  // one write port: clearing pass or accepted match
  always_comb begin
    mem_we    = sweeping | acc_write;
    mem_waddr = sweeping ? sweep_cnt : AW'(cand_index);
    mem_wdata = sweeping ? hdm_pkg::NO_DIST : cand_best;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_rdata <= dist_mem[rd_addr];
    end
  end

  // execute stage payload, forwarding a write that lands on the read edge
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_kind     <= head.kind;
      ex_dist     <= head_dist;
      ex_tidx     <= head.tidx;
      ex_last     <= head.last;
      ex_fwd_hit  <= acc_write && (AW'(cand_index) == rd_addr);
      ex_fwd_dist <= cand_best;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && ex_done) begin
      query_matched   <= accept;
      best_index      <= cand_index;
      best_distance   <= cand_best;
      second_distance <= cand_second;
      match_count     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid   <= 1'b0;
      out_valid  <= 1'b0;
      sweeping   <= 1'b1;
      sweep_cnt  <= '0;
      run_best   <= hdm_pkg::NO_DIST;
      run_second <= hdm_pkg::NO_DIST;
      run_index  <= '0;
      count      <= '0;
    end else begin
      if (pop) begin
        ex_valid <= 1'b1;
      end else if (ex_done) begin
        ex_valid <= 1'b0;
      end

      if (emit && ex_done) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end

      if (sweeping) begin
        if (sweep_cnt == AW'(MAX_TARGETS - 1)) begin
          sweeping <= 1'b0;
        end else begin
          sweep_cnt <= sweep_cnt + 1'b1;
        end
      end

      if (ex_done) begin
        unique case (ex_kind)
          hdm_pkg::KIND_CLEAR: begin
            run_best   <= hdm_pkg::NO_DIST;
            run_second <= hdm_pkg::NO_DIST;
            run_index  <= '0;
            count      <= '0;
            sweeping   <= 1'b1;
            sweep_cnt  <= '0;
          end
          hdm_pkg::KIND_LOAD: begin
            run_best   <= hdm_pkg::NO_DIST;
            run_second <= hdm_pkg::NO_DIST;
            run_index  <= '0;
          end
          hdm_pkg::KIND_CAND: begin
            if (ex_last) begin
              run_best   <= hdm_pkg::NO_DIST;
              run_second <= hdm_pkg::NO_DIST;
              run_index  <= '0;
              count      <= count_next;
            end else begin
              run_best   <= cand_best;
              run_second <= cand_second;
              run_index  <= cand_index;
            end
          end
          default: begin
            run_best <= run_best;
          end
        endcase
      end
    end
  end

  // table is never read while the clearing pass runs
  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !pop)
    else $error("table read during clearing pass");

  a_exec_empty_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !ex_valid)
    else $error("execute stage busy during clearing pass");

  a_best_le_second: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_distance <= second_distance)
    else $error("best distance above second distance");

  a_match_has_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && query_matched) |-> (best_distance != hdm_pkg::NO_DIST &&
                                      best_distance <= threshold))
    else $error("accepted match without a valid distance");

endmodule

[design/hamming_descriptor_matcher.sv]
// Hamming descriptor matcher: a query descriptor is loaded, then candidate
// descriptors stream in one per cycle while in_stall is low; each candidate's
// per-word popcounts of the 256-bit XOR are taken on the input edge, queued,
// then summed and checked against the per-target table and the running
// best/second trackers. The last candidate of a query gives one result
// transfer. Sustained rate is one item per cycle when out_stall and clears do
// not hold it, set by the execute stage (one table read, one compare chain).
// After reset and after every clear action the distance table is swept to the
// empty value one entry a cycle, with in_stall held high.
// The threshold register sits at byte address 0 of the APB-style port.
// Files: hdm_pkg, hdm_front, hdm_fifo, hdm_back.
module hamming_descriptor_matcher #(
  parameter int DESC_WORDS  = 4,
  parameter int MAX_TARGETS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_0,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_1,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_2,
  input  logic [hdm_pkg::WORD_W-1:0]    desc_3,
  input  logic [hdm_pkg::IDX_W-1:0]     target_index,
  input  logic                          last_candidate,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          query_matched,
  output logic [hdm_pkg::IDX_W-1:0]     best_index,
  output logic [hdm_pkg::DIST_W-1:0]    best_distance,
  output logic [hdm_pkg::DIST_W-1:0]    second_distance,
  output logic [hdm_pkg::CNT_W-1:0]     match_count,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdm_pkg::APB_AW-1:0]    paddr,
  input  logic [hdm_pkg::APB_DW-1:0]    pwdata,
  output logic [hdm_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [hdm_pkg::THR_W-1:0] match_threshold;
  logic                      thr_sel;
  hdm_pkg::q_entry_t         push_data;
  hdm_pkg::q_entry_t         q_head;
  hdm_pkg::q_status_t        q_status;
  logic                      push;
  logic                      pop;
  logic                      sweeping;

  // register file: word index is paddr[2]
  assign pready  = 1'b1;
  assign thr_sel = (paddr[2] == hdm_pkg::REG_MATCH_THRESHOLD);
  assign prdata  = thr_sel ? hdm_pkg::APB_DW'(match_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= hdm_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready && thr_sel) begin
      match_threshold <= pwdata[hdm_pkg::THR_W-1:0];
    end
  end

  // front: accept, hold query, popcount per word
  hdm_front #(
    .DESC_WORDS (DESC_WORDS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .desc_0         (desc_0),
    .desc_1         (desc_1),
    .desc_2         (desc_2),
    .desc_3         (desc_3),
    .target_index   (target_index),
    .last_candidate (last_candidate),
    .q_status       (q_status),
    .sweeping       (sweeping),
    .push           (push),
    .push_data      (push_data)
  );

  // decoupling queue
  hdm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back: table lookup, tracking, results, clearing pass
  hdm_back #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .q_status        (q_status),
    .pop             (pop),
    .sweeping        (sweeping),
    .threshold       (match_threshold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .query_matched   (query_matched),
    .best_index      (best_index),
    .best_distance   (best_distance),
    .second_distance (second_distance),
    .match_count     (match_count)
  );

endmodule

[verif/hamming_descriptor_matcher_tb.sv]
// Self-checking testbench for hamming_descriptor_matcher: directed table, random
// query/candidate traffic and threshold sweeps.
// Depends on design/hdm_pkg.sv and design/hamming_descriptor_matcher.sv.
`timescale 1ns / 100ps

module hamming_descriptor_matcher_tb;

  localparam int TARGETS      = 1024;
  localparam int DRAIN_CYCLES = 8;      // pipeline + queue depth, with margin
  localparam int PHASE_ITEMS  = 380;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic [4*hdm_pkg::WORD_W-1:0] desc_t;

  // one input transfer
  typedef struct packed {
    logic [1:0]                act;
    desc_t                     desc;
    logic [hdm_pkg::IDX_W-1:0] tidx;
    logic                      last;
  } stim_t;

  // one result transfer
  typedef struct packed {
    logic                       matched;
    logic [hdm_pkg::IDX_W-1:0]  idx;
    logic [hdm_pkg::DIST_W-1:0] best;
    logic [hdm_pkg::DIST_W-1:0] second;
    logic [hdm_pkg::CNT_W-1:0]  count;
  } match_t;

  typedef struct {
    stim_t  s;
    bit     typed;   // expected result given in the row itself
    match_t want;
  } plan_row_t;

  // DUT ports
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   action = hdm_pkg::ACT_CLEAR;
  logic [hdm_pkg::WORD_W-1:0]   desc_0 = '0;
  logic [hdm_pkg::WORD_W-1:0]   desc_1 = '0;
  logic [hdm_pkg::WORD_W-1:0]   desc_2 = '0;
  logic [hdm_pkg::WORD_W-1:0]   desc_3 = '0;
  logic [hdm_pkg::IDX_W-1:0]    target_index = '0;
  logic                         last_candidate = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         query_matched;
  logic [hdm_pkg::IDX_W-1:0]    best_index;
  logic [hdm_pkg::DIST_W-1:0]   best_distance;
  logic [hdm_pkg::DIST_W-1:0]   second_distance;
  logic [hdm_pkg::CNT_W-1:0]    match_count;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [hdm_pkg::APB_AW-1:0]   paddr = '0;
  logic [hdm_pkg::APB_DW-1:0]   pwdata = '0;
  logic [hdm_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // predictor state
  desc_t                      nm_query;
  logic [hdm_pkg::DIST_W-1:0] nm_best;
  logic [hdm_pkg::DIST_W-1:0] nm_second;
  logic [hdm_pkg::IDX_W-1:0]  nm_best_idx;
  logic [hdm_pkg::DIST_W-1:0] nm_dist_tab [TARGETS];
  logic [hdm_pkg::CNT_W-1:0]  nm_count;
  logic [hdm_pkg::THR_W-1:0]  nm_thresh;

  match_t    pending_matches[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  bit        src_steady = 1'b0;    // sender never idles while set
  bit        sink_throttle = 1'b1; // receiver stalls at random while set
  int        stall_left = 0;
  int        stall_pick;

  hamming_descriptor_matcher #(
    .DESC_WORDS  (4),
    .MAX_TARGETS (TARGETS)
  ) i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .action, .desc_0, .desc_1, .desc_2, .desc_3,
    .target_index, .last_candidate,
    .out_valid, .out_stall, .query_matched, .best_index, .best_distance,
    .second_distance, .match_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void restart_trackers();
    nm_best     = hdm_pkg::NO_DIST;
    nm_second   = hdm_pkg::NO_DIST;
    nm_best_idx = '0;
  endfunction

  function automatic void clear_targets();
    foreach (nm_dist_tab[i]) nm_dist_tab[i] = hdm_pkg::NO_DIST;
    nm_count = '0;
  endfunction

  // Advances the model by one accepted transfer; returns 1 when a result is due.
  function automatic bit nearest_match_step(input stim_t s, output match_t r);
    logic [hdm_pkg::DIST_W-1:0] d;
    bit                         take;
    r = '0;
    case (s.act)
      hdm_pkg::ACT_CLEAR: begin
        clear_targets();
        restart_trackers();
        return 1'b0;
      end
      hdm_pkg::ACT_LOAD: begin
        nm_query = s.desc;
        restart_trackers();
        return 1'b0;
      end
      hdm_pkg::ACT_CAND: begin
        d = hdm_pkg::DIST_W'($countones(nm_query ^ s.desc));
        // a target already holding an equal or closer match is skipped
        if (nm_dist_tab[s.tidx] > d) begin
          if (d < nm_best) begin
            nm_second   = nm_best;
            nm_best     = d;
            nm_best_idx = s.tidx;
          end else if (d < nm_second) begin
            nm_second = d;   // ties with best land here, earlier index wins
          end
        end
        if (!s.last) return 1'b0;
        take = (nm_best != hdm_pkg::NO_DIST) && (nm_best <= nm_thresh);
        if (take) begin
          nm_dist_tab[nm_best_idx] = nm_best;
          if (nm_count != '1) nm_count = nm_count + 1'b1;
        end
        r = '{take, nm_best_idx, nm_best, nm_second, nm_count};
        restart_trackers();
        return 1'b1;
      end
      default: return 1'b0;   // unused action: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic desc_t low_bits(input int n);
    return (n >= 4*hdm_pkg::WORD_W) ? '1 : ((desc_t'(1) << n) - 1'b1);
  endfunction

  // mask with exactly k set bits at random places
  function automatic desc_t scatter(input int k);
    desc_t m;
    int    need;
    bit    inv;
    inv  = (k > 128);
    need = inv ? 256 - k : k;
    m    = '0;
    while ($countones(m) < need) m[$urandom_range(0, 255)] = 1'b1;
    return inv ? ~m : m;
  endfunction

  function automatic desc_t rand_desc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  // distances cluster around the threshold and the extremes
  function automatic int pick_dist();
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      d = int'(nm_thresh) + int'($urandom_range(0, 20)) - 10;
      return (d < 0) ? 0 : (d > 256) ? 256 : d;
    end
    if (r < 60) return $urandom_range(0, 20);
    if (r < 85) return $urandom_range(0, 256);
    if (r < 92) return 0;
    return 256;
  endfunction

  function automatic logic [hdm_pkg::IDX_W-1:0] pick_target();
    // a small pool makes the per-target skip fire often
    if ($urandom_range(0, 9) < 7) return hdm_pkg::IDX_W'($urandom_range(0, 31));
    return hdm_pkg::IDX_W'($urandom_range(0, TARGETS - 1));
  endfunction

  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel driver: one transfer, predicted when accepted
  // ---------------------------------------------------------------------------
  task automatic send(input stim_t s, input bit typed = 1'b0, input match_t want = '0);
    int     gap;
    match_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= s.act;
    desc_0         <= s.desc[63:0];
    desc_1         <= s.desc[127:64];
    desc_2         <= s.desc[191:128];
    desc_3         <= s.desc[255:192];
    target_index   <= s.tidx;
    last_candidate <= s.last;
    do @(posedge clk); while (in_stall);
    if (nearest_match_step(s, r)) pending_matches.push_back(typed ? want : r);
  endtask

  // Block idle: all results back, table sweep done, pipeline flushed.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic set_threshold(input logic [hdm_pkg::THR_W-1:0] thr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hdm_pkg::APB_AW'({hdm_pkg::REG_MATCH_THRESHOLD, 2'b00});
    pwdata  <= hdm_pkg::APB_DW'(thr);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    nm_thresh = thr;
  endtask

  // Random traffic, mostly well-formed queries with random content.
  task automatic run_traffic(input int n_items);
    int    sent;
    int    next_mix;
    int    r;
    int    n;
    stim_t s;
    desc_t q;
    sent     = 0;
    next_mix = 0;
    while (sent < n_items) begin
      if (sent >= next_mix) begin
        // switch between idling and back-to-back stretches
        src_steady    = ($urandom_range(0, 3) == 0);
        sink_throttle = ($urandom_range(0, 3) != 0);
        next_mix      = sent + $urandom_range(60, 160);
      end
      r = $urandom_range(0, 99);
      if (r < 78) begin
        q = rand_desc();
        s = '{hdm_pkg::ACT_LOAD, q, hdm_pkg::IDX_W'($urandom), 1'($urandom)};
        send(s);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          s = '{hdm_pkg::ACT_CAND, q ^ scatter(pick_dist()), pick_target(),
                1'(j == n - 1)};
          send(s);
        end
        sent += n + 1;
      end else if (r < 88) begin
        // broken run: candidates against whatever query is loaded, often no last
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) begin
          s = '{hdm_pkg::ACT_CAND, nm_query ^ scatter(pick_dist()), pick_target(),
                1'($urandom_range(0, 3) == 0)};
          send(s);
        end
        sent += n;
      end else if (r < 95) begin
        s = '{ACT_UNUSED, rand_desc(), hdm_pkg::IDX_W'($urandom), 1'($urandom)};
        send(s);   // ignored by the block
        sent++;
      end else if (r < 97) begin
        s = '{hdm_pkg::ACT_CLEAR, rand_desc(), hdm_pkg::IDX_W'($urandom), 1'($urandom)};
        send(s);
        sent++;
      end else begin
        s = '{2'($urandom_range(0, 2)), rand_desc(), hdm_pkg::IDX_W'($urandom),
              1'($urandom)};
        send(s);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random stall and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !sink_throttle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (stall_pick < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_pick < 98) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(3, 10);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  task automatic flag(input string msg);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    match_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        flag("result transfer with nothing expected");
      end else begin
        w = pending_matches.pop_front();
        if (query_matched !== w.matched)
          flag($sformatf("query_matched %0b, want %0b", query_matched, w.matched));
        if (best_index !== w.idx)
          flag($sformatf("best_index %0d, want %0d", best_index, w.idx));
        if (best_distance !== w.best)
          flag($sformatf("best_distance %0d, want %0d", best_distance, w.best));
        if (second_distance !== w.second)
          flag($sformatf("second_distance %0d, want %0d", second_distance, w.second));
        if (match_count !== w.count)
          flag($sformatf("match_count %0d, want %0d", match_count, w.count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    desc_t qd;
    logic [hdm_pkg::THR_W-1:0] thr_plan [5];

    nm_query  = '0;
    nm_thresh = hdm_pkg::THRESH_RESET;
    restart_trackers();
    clear_targets();

    qd = {64'h3C3C_C3C3_9696_6969, 64'hA5A5_5A5A_0F0F_F0F0,
          64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF};

    // Directed table, threshold at its reset value of 50. Query is zero after
    // reset, so the first rows are read straight off.
    plan.push_back('{'{hdm_pkg::ACT_CAND, '0, 10'd5, 1'b1}, 1'b1,
                     '{1'b1, 10'd5, 9'd0, hdm_pkg::NO_DIST, 16'd1}});
    plan.push_back('{'{hdm_pkg::ACT_CAND, '1, 10'd1023, 1'b1}, 1'b1,
                     '{1'b0, 10'd1023, 9'd256, hdm_pkg::NO_DIST, 16'd1}});
    // same target again at equal distance: skipped, nothing qualifies
    plan.push_back('{'{hdm_pkg::ACT_CAND, '0, 10'd5, 1'b1}, 1'b1,
                     '{1'b0, 10'd0, hdm_pkg::NO_DIST, hdm_pkg::NO_DIST, 16'd1}});
    plan.push_back('{'{ACT_UNUSED, '1, 10'd1023, 1'b1}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_LOAD, qd, 10'd0, 1'b0}, 1'b0, '0});
    // tie at distance 1: second takes it, first index stays best
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(1), 10'd10, 1'b0}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ (desc_t'(1) << 255), 10'd11, 1'b0},
                     1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(3), 10'd12, 1'b1}, 1'b0, '0});
    // on and just past the threshold
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(50), 10'd20, 1'b1}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(51), 10'd21, 1'b1}, 1'b0, '0});
    // reload mid-query drops the open trackers
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd, 10'd30, 1'b0}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_LOAD, qd, 10'd0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(200), 10'd31, 1'b1}, 1'b0, '0});
    // target 10 holds distance 1, so both of these are skipped
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(60), 10'd10, 1'b0}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd ^ low_bits(2), 10'd10, 1'b1}, 1'b0, '0});
    // clear mid-query: table, count and trackers reset, query kept
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd, 10'd40, 1'b0}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CLEAR, '1, 10'd1023, 1'b1}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, qd, 10'd10, 1'b1}, 1'b1,
                     '{1'b1, 10'd10, 9'd0, hdm_pkg::NO_DIST, 16'd1}});
    plan.push_back('{'{hdm_pkg::ACT_LOAD, '1, 10'd1023, 1'b1}, 1'b0, '0});
    plan.push_back('{'{hdm_pkg::ACT_CAND, '0, 10'd0, 1'b1}, 1'b1,
                     '{1'b0, 10'd0, 9'd256, hdm_pkg::NO_DIST, 16'd1}});

    thr_plan[0] = 9'd0;
    thr_plan[1] = 9'd256;
    thr_plan[2] = hdm_pkg::THR_W'($urandom_range(2, 254));
    thr_plan[3] = 9'd1;
    thr_plan[4] = hdm_pkg::THRESH_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].s, plan[i].typed, plan[i].want);

    for (int p = 0; p < 5; p++) begin
      settle();
      set_threshold(thr_plan[p]);
      run_traffic(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("[hamming_descriptor_matcher] OK");
    end else begin
      $display("[hamming_descriptor_matcher] ERROR");
    end
    $finish;
  end

  // Slowest correct run is roughly ~1.9k items at worst gap plus worst stall,
  // and a few dozen table sweeps, well within the 4 ms timeout below.
  initial begin
    #4_000_000;
    $display("[hamming_descriptor_matcher] ERROR");
    $finish;
  end

endmodule
